@@ rtl/core/coo_to_csc_sparse_assembler_macros.svh @@
`ifndef COO_TO_CSC_SPARSE_ASSEMBLER_MACROS_SVH
`define COO_TO_CSC_SPARSE_ASSEMBLER_MACROS_SVH

// same-cycle implication, checked outside reset
`define CSA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define CSA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/csa_pkg.sv @@
package csa_pkg;

   localparam int CSA_MAX_ROWS  = 64;
   localparam int CSA_MAX_COLS  = 64;
   localparam int CSA_ACC_WIDTH = 48;

   localparam int IDX_W       = 7;
   localparam int VALUE_W     = 32;
   localparam int KIND_W      = 3;
   localparam int OUT_ROW_W   = 6;
   localparam int OUT_COL_W   = 6;
   localparam int OUT_VALUE_W = 48;
   localparam int PTR_W       = 13;
   localparam int CSR_IDX_W   = 1;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 80;

   localparam logic [IDX_W-1:0] NUM_RESET = 7'd64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_ROWS = 1'b0,
      CSR_NUM_COLS = 1'b1
   } csr_index_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD_OK   = 3'd0,
      KIND_BAD_INDEX = 3'd1,
      KIND_ENTRY     = 3'd2,
      KIND_COL_END   = 3'd3,
      KIND_ERROR     = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD_WR,
      ST_SCAN,
      ST_EMIT,
      ST_RESP
   } state_type;

endpackage

@@ rtl/core/csa_ram.sv @@
module csa_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 4096,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/coo_to_csc_sparse_assembler.sv @@
// coo to csc assembler: load beats (req_tuser = 0) add a q16.16 value into a dense
// accumulator at 1-based (row, column), summing duplicates with saturation at ACC_WIDTH
// bits; emit beats (req_tuser = 1) return the next nonzero entry in column-major,
// row-ascending order and clear it, or the column's end pointer once a column has no
// entries left, the final column end carrying rsp_tlast. a bad index gives a bad-index
// response and a sticky error after which every beat answers with the error kind until
// reset. the accumulators live in one single-port-read ram of MAX_ROWS*MAX_COLS words;
// after reset a clearing pass writes zero to every word, one per cycle, so no request
// is taken until the pass is done, csr writes being taken throughout. a load reads the
// ram, then adds and writes back; an emit beat scans the current column from its resume
// row, as the scan issues one ram read per cycle and checks each word in the cycle
// after, and then returns the first nonzero entry found or the column's end pointer.
// error and bad-index beats go straight to a response. a response waits in the output
// register until rsp_tready.
`include "coo_to_csc_sparse_assembler_macros.svh"

module coo_to_csc_sparse_assembler
   import csa_pkg::*;
#(
   parameter int MAX_ROWS  = CSA_MAX_ROWS,
   parameter int MAX_COLS  = CSA_MAX_COLS,
   parameter int ACC_WIDTH = CSA_ACC_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // row_index[6:0], col_index[13:7], value[45:14]
   input  logic                   req_tuser,  // mode
   // response stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // out_row[5:0], out_col[11:6],
                                              // out_value[59:12], col_pointer[72:60]
   output logic [KIND_W-1:0]      rsp_tuser,  // kind
   output logic                   rsp_tlast,  // last
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [IDX_W-1:0]       csr_data
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // ---------------------------------------------------------------- registers
   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         num_rows_ff, num_rows_in;
   logic [IDX_W-1:0]         num_cols_ff, num_cols_in;
   logic                     err_ff, err_in;
   logic [IDX_W-1:0]         scan_row_ff, scan_row_in;   // resume row of the open column
   logic [IDX_W-1:0]         scan_col_ff, scan_col_in;
   logic [PTR_W-1:0]         count_ff, count_in;         // nonzeros emitted this stream
   logic [IDX_W-1:0]         rd_row_ff, rd_row_in;       // next row to read
   logic [IDX_W-1:0]         chk_row_ff, chk_row_in;     // row whose word is on rd_data
   logic                     chk_valid_ff, chk_valid_in;
   logic [AW-1:0]            clr_addr_ff, clr_addr_in;
   logic [AW-1:0]            ld_addr_ff, ld_addr_in;
   logic signed [VALUE_W-1:0] ld_value_ff, ld_value_in;
   kind_type                 res_kind_ff, res_kind_in;   // pending immediate response
   logic                     res_last_ff, res_last_in;

   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   kind_type                 rsp_kind_ff, rsp_kind_in;
   logic [OUT_ROW_W-1:0]     rsp_row_ff, rsp_row_in;
   logic [OUT_COL_W-1:0]     rsp_col_ff, rsp_col_in;
   logic [OUT_VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [PTR_W-1:0]         rsp_ptr_ff, rsp_ptr_in;
   logic                     rsp_last_ff, rsp_last_in;

   // ---------------------------------------------------------------- ram
   logic                     ram_we, ram_re;
   logic [AW-1:0]            ram_waddr, ram_raddr;
   logic [ACC_WIDTH-1:0]     ram_wdata, ram_rdata;

   csa_ram #(
      .WIDTH (ACC_WIDTH),
      .DEPTH (DEPTH)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------- decode
   logic [IDX_W-1:0]          req_row, req_col;
   logic signed [VALUE_W-1:0] req_value;
   logic [IDX_W-1:0]          nr_eff, nc_eff;
   logic                      bad_idx;
   logic                      wrap;
   logic                      fin;
   logic                      slot_free;
   logic                      found;
   logic                      req_beat;
   logic [AW-1:0]             req_addr, scan_addr, emit_addr;

   assign req_row   = req_tdata[6:0];
   assign req_col   = req_tdata[13:7];
   assign req_value = signed'(req_tdata[45:14]);

   // effective counts: register value capped at the store size
   assign nr_eff = (32'(num_rows_ff) < MAX_ROWS) ? num_rows_ff : IDX_W'(MAX_ROWS);
   assign nc_eff = (32'(num_cols_ff) < MAX_COLS) ? num_cols_ff : IDX_W'(MAX_COLS);

   assign bad_idx = (req_row == '0) || (req_row > nr_eff) ||
                    (req_col == '0) || (req_col > nc_eff);

   // column-major word address: col * MAX_ROWS + row
   assign req_addr  = AW'((32'(req_col) - 32'd1) * MAX_ROWS + 32'(req_row) - 32'd1);
   assign scan_addr = AW'(32'(scan_col_ff) * MAX_ROWS + 32'(rd_row_ff));
   assign emit_addr = AW'(32'(scan_col_ff) * MAX_ROWS + 32'(chk_row_ff));

   assign wrap      = (scan_col_ff >= nc_eff);
   assign fin       = ({1'b0, scan_col_ff} + 8'd1) >= {1'b0, nc_eff};
   assign slot_free = !rsp_tvalid_ff || rsp_tready;
   assign found     = chk_valid_ff && (ram_rdata != '0);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // ---------------------------------------------------------------- saturating add
   logic signed [ACC_WIDTH-1:0] acc_old;
   logic signed [ACC_WIDTH:0]   acc_sum;
   logic [ACC_WIDTH-1:0]        acc_new;
   localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

   assign acc_old = signed'(ram_rdata);
   assign acc_sum = (ACC_WIDTH+1)'(acc_old) + (ACC_WIDTH+1)'(ld_value_ff);

   always_comb begin
      if (acc_sum[ACC_WIDTH] != acc_sum[ACC_WIDTH-1]) begin
         acc_new = acc_sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_new = acc_sum[ACC_WIDTH-1:0];
      end
   end

   // ---------------------------------------------------------------- output saturation
   logic [OUT_VALUE_W-1:0] ent_value;

   generate
      if (ACC_WIDTH > OUT_VALUE_W) begin : g_out_sat
         logic [ACC_WIDTH-OUT_VALUE_W:0] top_bits;
         assign top_bits = ram_rdata[ACC_WIDTH-1:OUT_VALUE_W-1];
         always_comb begin
            if ((top_bits == '0) || (top_bits == '1)) begin
               ent_value = ram_rdata[OUT_VALUE_W-1:0];
            end else if (ram_rdata[ACC_WIDTH-1]) begin
               ent_value = {1'b1, {(OUT_VALUE_W-1){1'b0}}};
            end else begin
               ent_value = {1'b0, {(OUT_VALUE_W-1){1'b1}}};
            end
         end
      end else begin : g_out_ext
         assign ent_value = OUT_VALUE_W'(acc_old);
      end
   endgenerate

   // ---------------------------------------------------------------- state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         num_rows_ff   <= NUM_RESET;
         num_cols_ff   <= NUM_RESET;
         err_ff        <= 1'b0;
         scan_row_ff   <= '0;
         scan_col_ff   <= '0;
         count_ff      <= '0;
         rd_row_ff     <= '0;
         chk_row_ff    <= '0;
         chk_valid_ff  <= 1'b0;
         clr_addr_ff   <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         num_rows_ff   <= num_rows_in;
         num_cols_ff   <= num_cols_in;
         err_ff        <= err_in;
         scan_row_ff   <= scan_row_in;
         scan_col_ff   <= scan_col_in;
         count_ff      <= count_in;
         rd_row_ff     <= rd_row_in;
         chk_row_ff    <= chk_row_in;
         chk_valid_ff  <= chk_valid_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      ld_addr_ff   <= ld_addr_in;
      ld_value_ff  <= ld_value_in;
      res_kind_ff  <= res_kind_in;
      res_last_ff  <= res_last_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ptr_ff   <= rsp_ptr_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in      = state_ff;
      num_rows_in   = num_rows_ff;
      num_cols_in   = num_cols_ff;
      err_in        = err_ff;
      scan_row_in   = scan_row_ff;
      scan_col_in   = scan_col_ff;
      count_in      = count_ff;
      rd_row_in     = rd_row_ff;
      chk_row_in    = chk_row_ff;
      chk_valid_in  = chk_valid_ff;
      clr_addr_in   = clr_addr_ff;
      ld_addr_in    = ld_addr_ff;
      ld_value_in   = ld_value_ff;
      res_kind_in   = res_kind_ff;
      res_last_in   = res_last_ff;

      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_ptr_in    = rsp_ptr_ff;
      rsp_last_in   = rsp_last_ff;

      ram_we    = 1'b0;
      ram_waddr = clr_addr_ff;
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = scan_addr;

      // register writes, taken in any state
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_NUM_ROWS: num_rows_in = csr_data;
            CSR_NUM_COLS: num_cols_in = csr_data;
            default:      ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            // load address and value captured every cycle; the read is issued only for a good load
            ram_raddr   = req_addr;
            ld_addr_in  = req_addr;
            ld_value_in = req_value;
            if (req_beat) begin
               priority if (err_ff) begin
                  res_kind_in = KIND_ERROR;
                  res_last_in = 1'b0;
                  state_in    = ST_RESP;
               end else if (!req_tuser) begin
                  if (bad_idx) begin
                     err_in      = 1'b1;
                     res_kind_in = KIND_BAD_INDEX;
                     res_last_in = 1'b0;
                     state_in    = ST_RESP;
                  end else begin
                     ram_re   = 1'b1;
                     state_in = ST_LOAD_WR;
                  end
               end else if (nc_eff == '0) begin
                  // no columns: lone column end for column 0
                  scan_row_in = '0;
                  scan_col_in = '0;
                  count_in    = '0;
                  res_kind_in = KIND_COL_END;
                  res_last_in = 1'b1;
                  state_in    = ST_RESP;
               end else begin
                  if (wrap) begin
                     scan_row_in = '0;
                     scan_col_in = '0;
                     count_in    = '0;
                  end
                  rd_row_in    = wrap ? '0 : scan_row_ff;
                  chk_valid_in = 1'b0;
                  state_in     = ST_SCAN;
               end
            end
         end

         ST_LOAD_WR: begin
            if (slot_free) begin
               ram_we        = 1'b1;
               ram_waddr     = ld_addr_ff;
               ram_wdata     = acc_new;
               rsp_tvalid_in = 1'b1;
               rsp_kind_in   = KIND_LOAD_OK;
               rsp_row_in    = '0;
               rsp_col_in    = '0;
               rsp_value_in  = '0;
               rsp_ptr_in    = '0;
               rsp_last_in   = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         ST_SCAN: begin
            if (found) begin
               state_in = ST_EMIT;
            end else if (rd_row_ff < nr_eff) begin
               // read one row, check it next cycle
               ram_re       = 1'b1;
               ram_raddr    = scan_addr;
               rd_row_in    = rd_row_ff + 1'b1;
               chk_row_in   = rd_row_ff;
               chk_valid_in = 1'b1;
            end else if (slot_free) begin
               // column exhausted: end pointer
               rsp_tvalid_in = 1'b1;
               rsp_kind_in   = KIND_COL_END;
               rsp_row_in    = '0;
               rsp_col_in    = scan_col_ff[OUT_COL_W-1:0];
               rsp_value_in  = '0;
               rsp_ptr_in    = count_ff;
               rsp_last_in   = fin;
               scan_row_in   = '0;
               scan_col_in   = fin ? '0 : scan_col_ff + 1'b1;
               count_in      = fin ? '0 : count_ff;
               chk_valid_in  = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         ST_EMIT: begin
            // rd_data holds the found word, no read issued here
            if (slot_free) begin
               ram_we        = 1'b1;
               ram_waddr     = emit_addr;
               ram_wdata     = '0;
               rsp_tvalid_in = 1'b1;
               rsp_kind_in   = KIND_ENTRY;
               rsp_row_in    = chk_row_ff[OUT_ROW_W-1:0];
               rsp_col_in    = scan_col_ff[OUT_COL_W-1:0];
               rsp_value_in  = ent_value;
               rsp_ptr_in    = '0;
               rsp_last_in   = 1'b0;
               count_in      = count_ff + 1'b1;
               scan_row_in   = chk_row_ff + 1'b1;
               chk_valid_in  = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         ST_RESP: begin
            if (slot_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_kind_in   = res_kind_ff;
               rsp_row_in    = '0;
               rsp_col_in    = '0;
               rsp_value_in  = '0;
               rsp_ptr_in    = '0;
               rsp_last_in   = res_last_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- outputs
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'd0, rsp_ptr_ff, rsp_value_ff, rsp_col_ff, rsp_row_ff};

   // ---------------------------------------------------------------- checks
   `CSA_ASSERT_NOW(a_no_req_in_clear, state_ff == ST_CLEAR, !req_tready,
      "request taken during clearing pass")
   `CSA_ASSERT_NEXT(a_err_sticky, err_ff, err_ff, "sticky error flag dropped")
   `CSA_ASSERT_NOW(a_entry_nonzero, rsp_tvalid_ff && (rsp_kind_ff == KIND_ENTRY),
      rsp_value_ff != '0, "entry beat with zero value")
   `CSA_ASSERT_NOW(a_write_states, ram_we,
      (state_ff == ST_CLEAR) || (state_ff == ST_LOAD_WR) || (state_ff == ST_EMIT),
      "accumulator written outside a write state")

endmodule

@@ test/csc_stream_checker.sv @@
module csc_stream_checker
   import csa_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [KIND_W-1:0]      rsp_tuser,
   input  logic                   rsp_tlast,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [IDX_W-1:0]       csr_data,
   output int                     mismatch_count,
   output int                     awaiting
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     STORE_DEPTH = CSA_MAX_ROWS * CSA_MAX_COLS;
   localparam longint ACC_MAX     = (longint'(1) << (CSA_ACC_WIDTH - 1)) - 1;
   localparam longint ACC_MIN     = -ACC_MAX - 1;

   // field offsets in the request and response beats
   localparam int COL_IN_LSB  = IDX_W;
   localparam int VAL_IN_LSB  = 2 * IDX_W;
   localparam int COL_OUT_LSB = OUT_ROW_W;
   localparam int VAL_OUT_LSB = OUT_ROW_W + OUT_COL_W;
   localparam int PTR_OUT_LSB = VAL_OUT_LSB + OUT_VALUE_W;

   typedef struct packed {
      kind_type               kind;
      logic [OUT_ROW_W-1:0]   row;
      logic [OUT_COL_W-1:0]   col;
      logic [OUT_VALUE_W-1:0] value;
      logic [PTR_W-1:0]       ptr;
      logic                   last;
   } csc_beat_type;

   longint           acc_store [STORE_DEPTH];
   logic [IDX_W-1:0] rows_cfg;
   logic [IDX_W-1:0] cols_cfg;
   int unsigned      scan_row;
   int unsigned      scan_col;
   logic [PTR_W-1:0] nnz_count;
   logic             sticky_error;
   csc_beat_type     pending_beats [$];

   function automatic int unsigned clip(logic [IDX_W-1:0] n, int unsigned cap);
      return (n < cap) ? n : cap;
   endfunction

   // next csc beat for one request, updating the shadow store and scan position
   function automatic csc_beat_type assemble_next(logic emit, logic [IDX_W-1:0] ri,
                                                  logic [IDX_W-1:0] ci,
                                                  logic [VALUE_W-1:0] raw);
      int unsigned  nr;
      int unsigned  nc;
      int unsigned  r;
      int unsigned  slot;
      logic         found;
      longint       sum;
      csc_beat_type res;
      nr        = clip(rows_cfg, CSA_MAX_ROWS);
      nc        = clip(cols_cfg, CSA_MAX_COLS);
      res.kind  = KIND_LOAD_OK;
      res.row   = '0;
      res.col   = '0;
      res.value = '0;
      res.ptr   = '0;
      res.last  = 1'b0;
      found     = 1'b0;
      slot      = 0;
      if (sticky_error) begin
         res.kind = KIND_ERROR;
      end else if (!emit) begin
         if (ri == 0 || ri > nr || ci == 0 || ci > nc) begin
            sticky_error = 1'b1;
            res.kind     = KIND_BAD_INDEX;
         end else begin
            slot = (ci - 1) * CSA_MAX_ROWS + (ri - 1);
            sum  = acc_store[slot] + longint'($signed(raw));
            if (sum > ACC_MAX) begin
               sum = ACC_MAX;
            end else if (sum < ACC_MIN) begin
               sum = ACC_MIN;
            end
            acc_store[slot] = sum;
         end
      end else if (nc == 0) begin
         scan_row  = 0;
         scan_col  = 0;
         nnz_count = '0;
         res.kind  = KIND_COL_END;
         res.last  = 1'b1;
      end else begin
         // position left past the columns in use: fresh stream
         if (scan_col >= nc) begin
            scan_row  = 0;
            scan_col  = 0;
            nnz_count = '0;
         end
         r = scan_row;
         while (!found && r < nr) begin
            slot = scan_col * CSA_MAX_ROWS + r;
            if (acc_store[slot] != 0) begin
               found = 1'b1;
            end else begin
               r++;
            end
         end
         if (found) begin
            res.kind        = KIND_ENTRY;
            res.row         = OUT_ROW_W'(r);
            res.col         = OUT_COL_W'(scan_col);
            res.value       = OUT_VALUE_W'(acc_store[slot]);
            acc_store[slot] = 0;
            nnz_count       = nnz_count + 1'b1;
            scan_row        = r + 1;
         end else begin
            res.kind = KIND_COL_END;
            res.col  = OUT_COL_W'(scan_col);
            res.ptr  = nnz_count;
            res.last = (scan_col + 1 >= nc);
            if (res.last) begin
               scan_col  = 0;
               nnz_count = '0;
            end else begin
               scan_col++;
            end
            scan_row = 0;
         end
      end
      return res;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      csc_beat_type want;
      if (reset) begin
         foreach (acc_store[i]) acc_store[i] = 0;
         rows_cfg     = NUM_RESET;
         cols_cfg     = NUM_RESET;
         scan_row     = 0;
         scan_col     = 0;
         nnz_count    = '0;
         sticky_error = 1'b0;
         pending_beats.delete();
         awaiting     = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_NUM_ROWS) begin
               rows_cfg = csr_data;
            end else begin
               cols_cfg = csr_data;
            end
         end
         // responses before requests, so a beat never meets its own expectation
         if (rsp_tvalid && rsp_tready) begin
            if (pending_beats.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response, expected none, actual kind %0d",
                        $time, rsp_tuser);
            end else begin
               want = pending_beats.pop_front();
               check_field("kind", want.kind, rsp_tuser);
               check_field("out_row", want.row, rsp_tdata[0 +: OUT_ROW_W]);
               check_field("out_col", want.col, rsp_tdata[COL_OUT_LSB +: OUT_COL_W]);
               check_field("out_value", want.value, rsp_tdata[VAL_OUT_LSB +: OUT_VALUE_W]);
               check_field("col_pointer", want.ptr, rsp_tdata[PTR_OUT_LSB +: PTR_W]);
               check_field("last", want.last, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready) begin
            pending_beats.push_back(assemble_next(req_tuser, req_tdata[0 +: IDX_W],
                                                  req_tdata[COL_IN_LSB +: IDX_W],
                                                  req_tdata[VAL_IN_LSB +: VALUE_W]));
         end
         awaiting = pending_beats.size();
      end
   end

endmodule

@@ test/tb_top.sv @@
module tb_top
   import csa_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // generous ceiling: clearing pass, long scans under stalls and the hold-offs
   localparam int LIMIT_CYCLES = 3_000_000;
   localparam int RANDOM_ITEMS = 1550;
   localparam int SAT_LOADS    = 24;
   localparam int HOLD_CYCLES  = 400;
   localparam int TAIL_CYCLES  = 100;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;  // row_index[6:0], col_index[13:7], value[45:14]
   logic                   req_tuser  = 1'b0;  // mode
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;  // out_row[5:0], out_col[11:6],
                                       // out_value[59:12], col_pointer[72:60]
   logic [KIND_W-1:0]      rsp_tuser;  // kind
   logic                   rsp_tlast;  // last
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = CSR_NUM_ROWS;
   logic [IDX_W-1:0]       csr_data   = '0;

   int          mismatch_count;
   int          awaiting;
   int          cycle_count = 0;
   int unsigned rsp_beats   = 0;
   int          burst_left  = 0;
   logic        offering    = 1'b0;  // shadow of req_tvalid, set in the same step
   logic        rush        = 1'b0;  // no gaps, receiver always ready (large-sum run)

   always #1 clock = ~clock;

   coo_to_csc_sparse_assembler u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   csc_stream_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .awaiting       (awaiting)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // response beats seen so far, read by the receiver at the falling edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_beats++;
      end
   end

   // receiver: changing stall patterns, plus a few long hold-offs so the block
   // backs up and has to stall its request side
   initial begin
      int unsigned hold_left;
      int unsigned pattern_left;
      int unsigned last_mark;
      int          stall_mode;
      logic        ready;
      hold_left    = 0;
      pattern_left = 0;
      last_mark    = 0;
      stall_mode   = 0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && rsp_beats % 500 == 250 && rsp_beats < 4000
             && rsp_beats != last_mark) begin
            last_mark = rsp_beats;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready = 1'b0;
         end else begin
            if (pattern_left == 0) begin
               stall_mode   = $urandom_range(0, 3);
               pattern_left = $urandom_range(16, 160);
            end
            pattern_left--;
            case (stall_mode)
               0: ready = 1'b1;
               1: ready = $urandom_range(0, 3) != 0;
               2: ready = $urandom_range(0, 3) == 0;
               default: ready = (pattern_left % 7) < 3;
            endcase
            if (rush) begin
               ready = 1'b1;
            end
         end
         rsp_tready <= ready;
      end
   end

   // one request beat; called at a falling edge, returns at a falling edge.
   // valid stays up between beats of a burst and drops only for a gap or a drain
   task automatic offer_beat(input logic emit, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col, input logic [VALUE_W-1:0] val);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= emit;
      req_tdata  <= REQ_TDATA_W'({val, col, row});
      offering    = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end
      if (burst_left == 0 && !rush) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            offering    = 1'b0;
            repeat (gap) @(negedge clock);
         end
         // now and then a long burst with no idling at all
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic load_beat(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                            input logic [VALUE_W-1:0] val);
      offer_beat(1'b0, row, col, val);
   endtask

   // emit beats carry random junk in the unused fields
   task automatic emit_beat();
      offer_beat(1'b1, IDX_W'($urandom), IDX_W'($urandom), $urandom);
   endtask

   // sender pause until every outstanding response is back
   task automatic drain();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering    = 1'b0;
      end
      @(negedge clock);
      while (awaiting != 0) @(negedge clock);
   endtask

   // leaves csr_valid high so back-to-back writes never drop it within a step
   task automatic write_reg(input csr_index_type idx, input logic [IDX_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_shape(input logic [IDX_W-1:0] rows, input logic [IDX_W-1:0] cols);
      write_reg(CSR_NUM_ROWS, rows);
      write_reg(CSR_NUM_COLS, cols);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return VALUE_W'($urandom_range(0, 255)) << 16;  // whole numbers, zero too
         3: return -VALUE_W'($urandom_range(1, 65536));
         default: return $urandom;
      endcase
   endfunction

   // 1-based index within 1..n, leaning on the edges
   function automatic logic [IDX_W-1:0] pick_index(input logic [IDX_W-1:0] n);
      case ($urandom_range(0, 5))
         0: return 1;
         1: return n;
         default: return IDX_W'($urandom_range(1, n));
      endcase
   endfunction

   initial begin
      int               random_items;
      int               batch;
      int               emits;
      logic [IDX_W-1:0] rows;
      logic [IDX_W-1:0] cols;
      logic [IDX_W-1:0] r;
      logic [IDX_W-1:0] c;
      random_items = 0;
      r            = 1;
      c            = 1;

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      set_shape(7'd64, 7'd64);
      // duplicates summing past 32 bits, corners, a pair cancelling to zero
      load_beat(7'd1, 7'd1, 32'h7FFF_FFFF);
      load_beat(7'd1, 7'd1, 32'h0000_0001);
      load_beat(7'd64, 7'd64, 32'h8000_0000);
      load_beat(7'd64, 7'd1, 32'h0001_0000);
      load_beat(7'd1, 7'd64, 32'hFFFF_0000);
      load_beat(7'd33, 7'd2, 32'h1234_5678);
      load_beat(7'd33, 7'd2, 32'hEDCB_A988);
      load_beat(7'd30, 7'd2, 32'h5555_5555);
      load_beat(7'd31, 7'd2, 32'hAAAA_AAAA);
      drain();
      // two columns in use: column 64 entries stay put for later streams
      set_shape(7'd64, 7'd2);
      emit_beat();
      load_beat(7'd2, 7'd1, 32'h0000_0007);  // ahead of the scan, same stream
      load_beat(7'd1, 7'd1, 32'h0000_0003);  // behind the scan, next stream
      repeat (6) emit_beat();  // rest of the stream up to the last column end
      repeat (2) emit_beat();  // a new stream picks up the late entry
      drain();
      // no rows or columns in use: column end with last on every emit
      set_shape(7'd0, 7'd0);
      repeat (2) emit_beat();

      // ---- random part: load batches followed by whole or partial streams ----
      while (random_items < RANDOM_ITEMS) begin
         drain();
         case ($urandom_range(0, 7))
            0: begin rows = 7'd64; cols = 7'd64; end
            1: begin rows = 7'd0;  cols = IDX_W'($urandom_range(0, 64)); end
            2: begin rows = IDX_W'($urandom_range(0, 64)); cols = 7'd0; end
            3: begin rows = 7'd1;  cols = 7'd1; end
            4: begin rows = 7'd64; cols = IDX_W'($urandom_range(1, 3)); end
            5: begin rows = IDX_W'($urandom_range(1, 4)); cols = 7'd64; end
            default: begin
               rows = IDX_W'($urandom_range(1, 64));
               cols = IDX_W'($urandom_range(1, 16));
            end
         endcase
         set_shape(rows, cols);
         repeat ($urandom_range(1, 3)) begin
            if (rows == 0 || cols == 0) begin
               // any load would be a bad index here, so emits only
               repeat ($urandom_range(1, 4)) begin
                  emit_beat();
                  random_items++;
               end
            end else begin
               batch = $urandom_range(1, 12);
               for (int i = 0; i < batch; i++) begin
                  // sometimes hit the same cell again to sum duplicates
                  if (i == 0 || $urandom_range(0, 3) != 0) begin
                     r = pick_index(rows);
                     c = pick_index(cols);
                  end
                  load_beat(r, c, pick_value());
                  random_items++;
               end
               emits = batch + cols;
               if ($urandom_range(0, 3) == 0) begin
                  emits = $urandom_range(1, emits);  // stop mid-stream
               end
               repeat (emits) begin
                  if ($urandom_range(0, 11) == 0) begin
                     load_beat(pick_index(rows), pick_index(cols), pick_value());
                     random_items++;
                  end
                  emit_beat();
                  random_items++;
               end
            end
         end
      end

      // ---- large duplicate sums both ways, back to back ----
      drain();
      set_shape(7'd64, 7'd0);
      emit_beat();  // puts the scan back at the start
      drain();
      set_shape(7'd64, 7'd64);
      rush <= 1'b1;
      repeat (SAT_LOADS) begin
         load_beat(7'd1, 7'd1, 32'h7FFF_FFFF);
         load_beat(7'd2, 7'd1, 32'h8000_0000);
      end
      repeat (3) emit_beat();
      rush <= 1'b0;

      // ---- bad index, then the sticky error on everything after ----
      drain();
      set_shape(7'd40, 7'd50);
      load_beat(7'd40, 7'd50, pick_value());
      emit_beat();
      case ($urandom_range(0, 3))
         0: load_beat('0, pick_index(7'd50), pick_value());
         1: load_beat(pick_index(7'd40), '0, pick_value());
         2: load_beat(IDX_W'($urandom_range(41, 64)), pick_index(7'd50), pick_value());
         default: load_beat(pick_index(7'd40), IDX_W'($urandom_range(51, 64)), pick_value());
      endcase
      repeat (12) begin
         if ($urandom_range(0, 1) == 0) begin
            emit_beat();
         end else begin
            load_beat(IDX_W'($urandom_range(0, 64)), IDX_W'($urandom_range(0, 64)),
                      pick_value());
         end
      end

      // ---- wind down ----
      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && awaiting == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/csa_pkg.sv
rtl/core/csa_ram.sv
rtl/core/coo_to_csc_sparse_assembler.sv
test/csc_stream_checker.sv
test/tb_top.sv
